### rtl/dmis_pkg.sv
// Package for the deduplicating sorter.
// Holds the item structs and the back-end state encoding; no dependencies.
package dmis_pkg;

    localparam int VALUE_W = 31;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               final_flag;
        logic               dups_seen;
        logic               overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_PLACE,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } eng_state_t;

endpackage

### rtl/dmis_queue.sv
// Front end: a two-entry item queue between the input port and the engine.
// Depends on dmis_pkg.
module dmis_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dmis_pkg::in_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output dmis_pkg::in_item_t head
);

    dmis_pkg::in_item_t slot_reg [2];
    logic               rd_ptr_reg, rd_ptr_next;
    logic               wr_ptr_reg, wr_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/dmis_engine.sv
// Back end: keeps the store sorted by insertion, drops duplicates and
// emits the set through an output register. Depends on dmis_pkg.
module dmis_engine
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  dmis_pkg::in_item_t  q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output dmis_pkg::out_item_t out_data
);

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ITEMS);

    logic [dmis_pkg::VALUE_W-1:0] store [MAX_ITEMS];
    logic [dmis_pkg::VALUE_W-1:0] rdata_reg;

    dmis_pkg::eng_state_t state_reg, state_next;
    dmis_pkg::in_item_t   cur_reg, cur_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 dup_reg, dup_next;
    logic                 ovf_reg, ovf_next;
    logic                 out_valid_reg, out_valid_next;
    dmis_pkg::out_item_t  out_data_reg, out_data_next;

    logic                 mem_rd;
    logic [IW-1:0]        mem_raddr;
    logic                 mem_wr;
    logic [IW-1:0]        mem_waddr;
    logic [dmis_pkg::VALUE_W-1:0] mem_wdata;
    logic                 slot_free;
    logic                 emit_final;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign slot_free  = !out_valid_reg || out_ready;
    assign emit_final = (idx_reg + CW'(1)) == count_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dmis_pkg::ST_IDLE:
                if (!q_empty) state_next = dmis_pkg::ST_SCAN;
            dmis_pkg::ST_SCAN:
                state_next = (idx_reg == count_reg) ? dmis_pkg::ST_PLACE
                                                    : dmis_pkg::ST_SCAN_CMP;
            dmis_pkg::ST_SCAN_CMP:
                if (rdata_reg == cur_reg.value)
                    state_next = cur_reg.last ? dmis_pkg::ST_EMIT_RD : dmis_pkg::ST_IDLE;
                else if (rdata_reg > cur_reg.value)
                    state_next = dmis_pkg::ST_PLACE;
                else
                    state_next = dmis_pkg::ST_SCAN;
            dmis_pkg::ST_PLACE:
                if (count_reg == FULL_COUNT)
                    state_next = cur_reg.last ? dmis_pkg::ST_EMIT_RD : dmis_pkg::ST_IDLE;
                else
                    state_next = dmis_pkg::ST_SHIFT;
            dmis_pkg::ST_SHIFT:
                if (idx_reg == pos_reg)
                    state_next = cur_reg.last ? dmis_pkg::ST_EMIT_RD : dmis_pkg::ST_IDLE;
                else
                    state_next = dmis_pkg::ST_SHIFT_WR;
            dmis_pkg::ST_SHIFT_WR:
                state_next = dmis_pkg::ST_SHIFT;
            dmis_pkg::ST_EMIT_RD:
                state_next = dmis_pkg::ST_EMIT_LD;
            dmis_pkg::ST_EMIT_LD:
                if (slot_free)
                    state_next = emit_final ? dmis_pkg::ST_IDLE : dmis_pkg::ST_EMIT_RD;
            default:
                state_next = dmis_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        cur_next       = cur_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        dup_next       = dup_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        mem_rd         = 1'b0;
        mem_raddr      = idx_reg[IW-1:0];
        mem_wr         = 1'b0;
        mem_waddr      = idx_reg[IW-1:0];
        mem_wdata      = rdata_reg;
        unique case (state_reg)
            dmis_pkg::ST_IDLE:
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    idx_next = '0;
                end
            dmis_pkg::ST_SCAN:
                if (idx_reg == count_reg)
                    pos_next = count_reg;
                else
                    mem_rd = 1'b1;
            dmis_pkg::ST_SCAN_CMP:
                if (rdata_reg == cur_reg.value)
                begin
                    dup_next = 1'b1;
                    idx_next = '0;
                end
                else if (rdata_reg > cur_reg.value)
                    pos_next = idx_reg;
                else
                    idx_next = idx_reg + CW'(1);
            dmis_pkg::ST_PLACE:
                if (count_reg == FULL_COUNT)
                begin
                    ovf_next = 1'b1;
                    idx_next = '0;
                end
                else
                    idx_next = count_reg;
            dmis_pkg::ST_SHIFT:
                if (idx_reg == pos_reg)
                begin
                    // Shifting is done; drop the new value into its slot.
                    mem_wr     = 1'b1;
                    mem_wdata  = cur_reg.value;
                    count_next = count_reg + CW'(1);
                    idx_next   = '0;
                end
                else
                begin
                    mem_rd    = 1'b1;
                    mem_raddr = IW'(idx_reg - CW'(1));
                end
            dmis_pkg::ST_SHIFT_WR:
            begin
                mem_wr   = 1'b1;
                idx_next = idx_reg - CW'(1);
            end
            dmis_pkg::ST_EMIT_RD:
                mem_rd = 1'b1;
            dmis_pkg::ST_EMIT_LD:
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.sorted_value = rdata_reg;
                    out_data_next.final_flag   = emit_final;
                    out_data_next.dups_seen    = dup_reg;
                    out_data_next.overflow     = ovf_reg;
                    idx_next                   = idx_reg + CW'(1);
                    if (emit_final)
                    begin
                        count_next = '0;
                        dup_next   = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmis_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            dup_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            dup_reg       <= dup_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            store[mem_waddr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            rdata_reg <= store[mem_raddr];
        end
    end

endmodule

### rtl/dedup_merge_insertion_sorter.sv
// Deduplicating sorter. Values are kept in ascending order as they arrive: each
// item from the input queue is compared against the held values one memory read
// at a time (a read in SCAN, a compare in SCAN_CMP), larger values are moved up
// by one slot (a read in SHIFT, a write in SHIFT_WR), and the new value is
// written in place. Duplicates are dropped and flagged, values past MAX_ITEMS
// are dropped and flagged as overflow. After the item marked last, the set
// streams out one value at a time, each read from the store (EMIT_RD) and then
// loaded into the output register (EMIT_LD) once it is free, the last one
// carrying final_flag. A two-entry queue lets the input keep taking items while
// the engine works. Depends on dmis_pkg, dmis_queue and dmis_engine.
module dedup_merge_insertion_sorter
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dmis_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dmis_pkg::out_item_t out_data
);

    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    dmis_pkg::in_item_t q_head;

    assign in_ready = !q_full;

    dmis_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_item (in_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    dmis_engine #(.MAX_ITEMS(MAX_ITEMS)) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/dmis_checker.sv
// Port-level checks for the deduplicating sorter, bound to the top level.
// Depends on dmis_pkg.
module dmis_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input dmis_pkg::out_item_t out_data
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // The markers are the same for every item of one set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.final_flag ##1 out_valid
        |-> out_data.dups_seen == $past(out_data.dups_seen))
        else $error("dups_seen changed inside a set");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.final_flag ##1 out_valid
        |-> out_data.overflow == $past(out_data.overflow))
        else $error("overflow changed inside a set");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result payload changed while stalled");

endmodule

bind dedup_merge_insertion_sorter dmis_checker u_dmis_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### test/dedup_merge_insertion_sorter_tb.sv
// Testbench for the deduplicating sorter: drives sets of values with random
// gaps, predicts the sorted unique output and checks every result item.
// Depends on dmis_pkg and dedup_merge_insertion_sorter.
`timescale 1ns / 100ps

module dedup_merge_insertion_sorter_tb;

    localparam int SET_CAP = 64;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    dmis_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    dmis_pkg::out_item_t out_data;

    dedup_merge_insertion_sorter u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    dmis_pkg::in_item_t  pending_items[$];
    dmis_pkg::out_item_t expected_sorted[$];

    // Predictor state: the values of the open set, kept in arrival order.
    logic [dmis_pkg::VALUE_W-1:0] set_values[$];
    logic                         set_dup;
    logic                         set_ovf;

    int  errors;
    int  accepted;
    int  results_seen;
    int  sets_closed;
    bit  stim_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic enqueue_item(input dmis_pkg::in_item_t item);
        begin
            pending_items = {pending_items, item};
        end
    endtask

    // Load one value into the open set; on last, sort and queue the results.
    task automatic predict_sorted(input dmis_pkg::in_item_t item);
        logic [dmis_pkg::VALUE_W-1:0] sorted[$];
        bit                           found;
        dmis_pkg::out_item_t          res;
        begin
            found = 1'b0;
            foreach (set_values[i])
                if (set_values[i] == item.value)
                    found = 1'b1;
            if (found)
                set_dup = 1'b1;
            else if (set_values.size() >= SET_CAP)
                set_ovf = 1'b1;
            else
                set_values = {set_values, item.value};
            if (item.last)
            begin
                sorted = set_values;
                sorted.sort();
                foreach (sorted[i])
                begin
                    res.sorted_value = sorted[i];
                    res.final_flag   = (i == sorted.size() - 1);
                    res.dups_seen    = set_dup;
                    res.overflow     = set_ovf;
                    expected_sorted  = {expected_sorted, res};
                end
                set_values.delete();
                set_dup = 1'b0;
                set_ovf = 1'b0;
                sets_closed++;
            end
        end
    endtask

    function automatic logic [dmis_pkg::VALUE_W-1:0] rand_value(input int mode);
        case (mode)
            0:       return 31'($urandom_range(0, 15));
            1:       return 31'({$urandom} & 32'h7FFF_FFFF);
            2:       return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
            default: return 31'(1) << $urandom_range(0, dmis_pkg::VALUE_W - 1);
        endcase
    endfunction

    task automatic queue_set(input int len, input int mode);
        dmis_pkg::in_item_t item;
        begin
            for (int i = 0; i < len; i++)
            begin
                item.value = rand_value(mode);
                item.last  = (i == len - 1);
                enqueue_item(item);
            end
        end
    endtask

    // Driver: bursts of random length separated by random gaps.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                accepted++;
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    in_data  <= pending_items[0];
                    in_valid <= 1'b1;
                    predict_sorted(pending_items.pop_front());
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0
                                                                  : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls in a pattern of its own, with long stall-free stretches.
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8])
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_sorted.size() == 0)
            begin
                $error("unexpected result item: sorted_value %0h", out_data.sorted_value);
                errors++;
            end
            else
            begin
                dmis_pkg::out_item_t exp_item;
                exp_item = expected_sorted.pop_front();
                if (out_data.sorted_value !== exp_item.sorted_value)
                begin
                    $error("sorted_value: expected %0h, got %0h",
                           exp_item.sorted_value, out_data.sorted_value);
                    errors++;
                end
                if (out_data.final_flag !== exp_item.final_flag)
                begin
                    $error("final_flag: expected %0b, got %0b",
                           exp_item.final_flag, out_data.final_flag);
                    errors++;
                end
                if (out_data.dups_seen !== exp_item.dups_seen)
                begin
                    $error("dups_seen: expected %0b, got %0b",
                           exp_item.dups_seen, out_data.dups_seen);
                    errors++;
                end
                if (out_data.overflow !== exp_item.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           exp_item.overflow, out_data.overflow);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dmis_pkg::in_item_t item;
        int                 len;
        int                 wait_cycles;
        errors       = 0;
        accepted     = 0;
        results_seen = 0;
        sets_closed  = 0;
        stim_done    = 1'b0;
        set_dup      = 1'b0;
        set_ovf      = 1'b0;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single-item set, extremes, duplicates, all-equal set.
        item.value = 31'h7FFF_FFFF; item.last = 1'b1; enqueue_item(item);
        item.value = 31'h0;         item.last = 1'b0; enqueue_item(item);
        item.value = 31'h7FFF_FFFF; item.last = 1'b0; enqueue_item(item);
        item.value = 31'h0;         item.last = 1'b0; enqueue_item(item);
        item.value = 31'h5555_5555; item.last = 1'b0; enqueue_item(item);
        item.value = 31'h2AAA_AAAA; item.last = 1'b1; enqueue_item(item);
        item.value = 31'h1;         item.last = 1'b0; enqueue_item(item);
        item.value = 31'h1;         item.last = 1'b1; enqueue_item(item);
        // Descending run of twelve values, each below the one before.
        for (int i = 0; i < 12; i++)
        begin
            item.value = 31'(100 - i);
            item.last  = (i == 11);
            enqueue_item(item);
        end

        // Random sets, mostly short.
        for (int s = 0; s < 7; s++)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            queue_set(len, $urandom_range(0, 3));
        end

        // Full store: 64 unique values, then overflow, then a duplicate while full.
        for (int i = 0; i < 64; i++)
        begin
            item.value = 31'({$urandom} & 32'h7FFF_FFC0) | 31'(i);
            item.last  = 1'b0;
            enqueue_item(item);
        end
        item.value = 31'h7FFF_FFFF; item.last = 1'b0; enqueue_item(item);
        item = pending_items[pending_items.size() - 2];
        item.last = 1'b1;
        enqueue_item(item);

        wait (pending_items.size() == 0 && !in_valid);
        stim_done = 1'b1;
        wait_cycles = 0;
        while (expected_sorted.size() != 0 && wait_cycles < 200_000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);

        $display("Sent %0d items in %0d sets; checked %0d sorted results.",
                 accepted, sets_closed, results_seen);
        if (errors == 0 && expected_sorted.size() == 0)
            $display("PASSED: all results match");
        else
        begin
            if (expected_sorted.size() != 0)
                $error("%0d expected results never arrived", expected_sorted.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
rtl/dmis_pkg.sv
rtl/dmis_queue.sv
rtl/dmis_engine.sv
rtl/dedup_merge_insertion_sorter.sv
rtl/dmis_checker.sv
test/dedup_merge_insertion_sorter_tb.sv
